// ----- src/lspg_pkg.sv -----
// Shared types and constants for the LED strip pattern generator.
// No dependencies; imported by lspg_ctrl and the top level.
`default_nettype none

package lspg_pkg;

  // Strip size limits and register reset
  localparam int unsigned MAX_PIXELS        = 64;
  localparam int unsigned SINE_TABLE_DEPTH  = 256;
  localparam logic [6:0]  PIXEL_COUNT_RESET = 7'd60;

  // Phase constants in units of 2^-24 turn
  localparam logic [23:0] STEP_TURN = 24'd534035;   // 0.2 rad
  localparam logic [23:0] OFFSET_G  = 24'd5340354;  // 2 rad
  localparam logic [23:0] OFFSET_B  = 24'd10680707; // 4 rad

  // Frame mode codes
  localparam logic MODE_RAINBOW = 1'b0;
  localparam logic MODE_COMET   = 1'b1;

  // Sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_FOLD,
    ST_COMET,
    ST_LOOK_G,
    ST_LOOK_R,
    ST_LOOK_B,
    ST_LOOK_END,
    ST_EMIT
  } lspg_state_e;

endpackage

`default_nettype wire

// ----- src/led_strip_pattern_generator_unit.sv -----
// LED strip pattern generator, top level.
// Input channel (in_valid_i/in_ready_o): one beat per frame tick carrying
// mode_i (0 rainbow, 1 comet) and the comet color red_i/green_i/blue_i.
// Output channel (out_valid_o/out_ready_i): pixel_count beats per frame,
// each a GRB word with its pixel index; last_pixel_o marks the final one.
// Config: cfg_we_i writes cfg_wdata_i into pixel_count (0 acts as 1,
// above 64 acts as 64); write it only while the block is idle.
// Sequencing: after accept, the head is reduced below the count in the
// fold state, by repeated subtraction after the count was lowered.
// Each rainbow pixel runs three lookups through the single sine table
// port, a state that takes the last registered table read, and an output
// state. Comet pixels run a comet state and an output state. in_ready_o
// is low from accept until the last beat is taken.
// A stalled receiver holds the current beat stable and freezes the frame.
// Reset: pixel_count = 60, head and phase = 0; the sine table is
// constant, so no clearing pass is needed.
// Depends on lspg_pkg, lspg_ctrl, lspg_wave.
`default_nettype none

module led_strip_pattern_generator_unit #(
  parameter int unsigned SINE_TABLE_DEPTH = lspg_pkg::SINE_TABLE_DEPTH
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_we_i,
  input  wire logic [6:0]  cfg_wdata_i,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic        mode_i,
  input  wire logic [7:0]  red_i,
  input  wire logic [7:0]  green_i,
  input  wire logic [7:0]  blue_i,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic [23:0]      pixel_word_o,
  output logic [5:0]       pixel_index_o,
  output logic             last_pixel_o
);

  import lspg_pkg::*;

  logic [6:0]  pixel_count_q;
  logic [23:0] wave_angle;
  logic [7:0]  wave_level;

  // Pixel count register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pixel_count_q <= PIXEL_COUNT_RESET;
    end else if (cfg_we_i) begin
      pixel_count_q <= cfg_wdata_i;
    end
  end

  lspg_ctrl u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .pixel_count_i (pixel_count_q),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .mode_i        (mode_i),
    .red_i         (red_i),
    .green_i       (green_i),
    .blue_i        (blue_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .pixel_word_o  (pixel_word_o),
    .pixel_index_o (pixel_index_o),
    .last_pixel_o  (last_pixel_o),
    .wave_angle_o  (wave_angle),
    .wave_level_i  (wave_level)
  );

  lspg_wave #(
    .SINE_TABLE_DEPTH (SINE_TABLE_DEPTH)
  ) u_wave (
    .clk_i   (clk_i),
    .angle_i (wave_angle),
    .level_o (wave_level)
  );

  // Never take a new frame while a pixel beat is offered
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(out_valid_o && in_ready_o))
    else $error("input ready while output beat pending");

  // Taking the last beat returns the block to idle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_ready_i && last_pixel_o) |=> in_ready_o)
    else $error("not idle after last pixel");

  // A non-final beat is followed by more work, not idle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_ready_i && !last_pixel_o) |=> !in_ready_o)
    else $error("frame ended before last pixel");

  // Accepting a frame starts work immediately
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> (!in_ready_o && !out_valid_o))
    else $error("frame accept did not start sequencing");

endmodule

`default_nettype wire

// ----- src/lspg_wave.sv -----
// Shared sine lookup unit: maps a 24-bit phase (fraction of a turn) to an
// 8-bit channel level through a constant table built at elaboration.
// Self-contained; no package needed.
`default_nettype none

module lspg_wave #(
  parameter int unsigned SINE_TABLE_DEPTH = 256
) (
  input  wire logic        clk_i,
  input  wire logic [23:0] angle_i,
  output logic [7:0]       level_o
);

  localparam int unsigned IdxW   = $clog2(SINE_TABLE_DEPTH);
  localparam int unsigned DepthW = $clog2(SINE_TABLE_DEPTH + 1);
  localparam logic [63:0] OneQ30    = 64'd1073741824;
  localparam logic [63:0] HalfPiQ30 = 64'd1686629713;

  typedef logic [7:0] wave_tab_t [SINE_TABLE_DEPTH];

  // One table entry: floor((sin(2*pi*k/depth)+1)*127.5), Taylor series in Q30
  function automatic logic [7:0] wave_entry(input int unsigned k);
    logic [63:0] t;
    logic [63:0] r;
    logic [63:0] x;
    logic [63:0] x2;
    logic [63:0] term;
    logic [63:0] sum;
    logic [63:0] mag;
    logic [63:0] biased;
    logic [63:0] v;
    logic [1:0]  quad;
    t    = (64'(k) << 32) / SINE_TABLE_DEPTH;
    quad = t[31:30];
    r    = {34'd0, t[29:0]};
    if (quad[0]) r = OneQ30 - r;
    x    = (r * HalfPiQ30) >> 30;
    x2   = (x * x) >> 30;
    term = x;
    sum  = x;
    term = ((term * x2) >> 30) / 64'd6;   sum = sum - term;
    term = ((term * x2) >> 30) / 64'd20;  sum = sum + term;
    term = ((term * x2) >> 30) / 64'd42;  sum = sum - term;
    term = ((term * x2) >> 30) / 64'd72;  sum = sum + term;
    term = ((term * x2) >> 30) / 64'd110; sum = sum - term;
    term = ((term * x2) >> 30) / 64'd156; sum = sum + term;
    mag    = (sum > OneQ30) ? OneQ30 : sum;
    biased = quad[1] ? (OneQ30 - mag) : (OneQ30 + mag);
    v      = (biased * 64'd255) >> 31;
    return (v > 64'd255) ? 8'd255 : v[7:0];
  endfunction

  function automatic wave_tab_t build_tab();
    wave_tab_t tab;
    for (int unsigned k = 0; k < SINE_TABLE_DEPTH; k++) begin
      tab[k] = wave_entry(k);
    end
    return tab;
  endfunction

  localparam wave_tab_t WaveTab = build_tab();

  // Table index: floor(angle * depth / 2^24)
  logic [24+DepthW-1:0] idx_prod;
  logic [IdxW-1:0]      idx;

  assign idx_prod = (24+DepthW)'(angle_i) * (24+DepthW)'(SINE_TABLE_DEPTH);
  assign idx      = idx_prod[24 +: IdxW];

  // Registered table read
  always_ff @(posedge clk_i) begin
    level_o <= WaveTab[idx];
  end

endmodule

`default_nettype wire

// ----- src/lspg_ctrl.sv -----
// Frame sequencer: walks the pixels of one frame, drives the shared sine
// lookup three times per rainbow pixel, builds comet words and holds the
// output beat. Depends on lspg_pkg.
`default_nettype none

module lspg_ctrl (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic [6:0]  pixel_count_i,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic        mode_i,
  input  wire logic [7:0]  red_i,
  input  wire logic [7:0]  green_i,
  input  wire logic [7:0]  blue_i,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic [23:0]      pixel_word_o,
  output logic [5:0]       pixel_index_o,
  output logic             last_pixel_o,
  output logic [23:0]      wave_angle_o,
  input  wire logic [7:0]  wave_level_i
);

  import lspg_pkg::*;

  lspg_state_e state_q, state_d;
  logic [5:0]  head_q, head_d;
  logic [23:0] phase_q, phase_d;
  logic [6:0]  cnt_q, cnt_d;
  logic [5:0]  pix_q, pix_d;
  logic [23:0] ang_q, ang_d;
  logic [23:0] word_q, word_d;
  logic        mode_q, mode_d;
  logic [7:0]  red_q, red_d, green_q, green_d, blue_q, blue_d;

  logic       is_last;
  logic [5:0] pix_gap;
  logic [6:0] head_inc;

  assign is_last  = ({1'b0, pix_q} == (cnt_q - 7'd1));
  assign pix_gap  = (pix_q > head_q) ? (pix_q - head_q) : (head_q - pix_q);
  assign head_inc = {1'b0, head_q} + 7'd1;

  assign in_ready_o    = (state_q == ST_IDLE);
  assign out_valid_o   = (state_q == ST_EMIT);
  assign pixel_word_o  = word_q;
  assign pixel_index_o = pix_q;
  assign last_pixel_o  = is_last;

  // Next state and datapath
  always_comb begin
    state_d      = state_q;
    head_d       = head_q;
    phase_d      = phase_q;
    cnt_d        = cnt_q;
    pix_d        = pix_q;
    ang_d        = ang_q;
    word_d       = word_q;
    mode_d       = mode_q;
    red_d        = red_q;
    green_d      = green_q;
    blue_d       = blue_q;
    wave_angle_o = ang_q;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          mode_d  = mode_i;
          red_d   = red_i;
          green_d = green_i;
          blue_d  = blue_i;
          pix_d   = '0;
          ang_d   = phase_q;
          if (pixel_count_i == 7'd0) begin
            cnt_d = 7'd1;
          end else if (pixel_count_i > 7'(MAX_PIXELS)) begin
            cnt_d = 7'(MAX_PIXELS);
          end else begin
            cnt_d = pixel_count_i;
          end
          state_d = ST_FOLD;
        end
      end
      // Reduce the head below the count by repeated subtraction
      ST_FOLD: begin
        if ({1'b0, head_q} >= cnt_q) begin
          head_d = head_q - cnt_q[5:0];
        end else begin
          state_d = (mode_q == MODE_COMET) ? ST_COMET : ST_LOOK_G;
        end
      end
      ST_COMET: begin
        case (pix_gap)
          6'd0:    word_d = {green_q, red_q, blue_q};
          6'd1:    word_d = {1'b0, green_q[7:1], 1'b0, red_q[7:1], 1'b0, blue_q[7:1]};
          6'd2:    word_d = {2'b0, green_q[7:2], 2'b0, red_q[7:2], 2'b0, blue_q[7:2]};
          default: word_d = '0;
        endcase
        state_d = ST_EMIT;
      end
      // Lookups issued G, R, B; each level returns in the cycle after its lookup
      ST_LOOK_G: begin
        wave_angle_o = ang_q + OFFSET_G;
        state_d      = ST_LOOK_R;
      end
      ST_LOOK_R: begin
        wave_angle_o  = ang_q;
        word_d[23:16] = wave_level_i;
        state_d       = ST_LOOK_B;
      end
      ST_LOOK_B: begin
        wave_angle_o = ang_q + OFFSET_B;
        word_d[15:8] = wave_level_i;
        state_d      = ST_LOOK_END;
      end
      ST_LOOK_END: begin
        word_d[7:0] = wave_level_i;
        state_d     = ST_EMIT;
      end
      // Hold the beat until taken, then step pixel or close the frame
      ST_EMIT: begin
        if (out_ready_i) begin
          if (is_last) begin
            head_d  = (head_inc == cnt_q) ? 6'd0 : head_inc[5:0];
            phase_d = phase_q + STEP_TURN;
            state_d = ST_IDLE;
          end else begin
            pix_d   = pix_q + 6'd1;
            ang_d   = ang_q + STEP_TURN;
            state_d = (mode_q == MODE_COMET) ? ST_COMET : ST_LOOK_G;
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      head_q  <= '0;
      phase_q <= '0;
      cnt_q   <= 7'd1;
      pix_q   <= '0;
    end else begin
      state_q <= state_d;
      head_q  <= head_d;
      phase_q <= phase_d;
      cnt_q   <= cnt_d;
      pix_q   <= pix_d;
    end
  end

  // Payload
  always_ff @(posedge clk_i) begin
    ang_q   <= ang_d;
    word_q  <= word_d;
    mode_q  <= mode_d;
    red_q   <= red_d;
    green_q <= green_d;
    blue_q  <= blue_d;
  end

endmodule

`default_nettype wire
